// ===== hdl/occupancy_grid_circle_update_assert.svh =====
// Assertion macros for the occupancy grid block.
// Used by the port checker; no other dependencies.
`ifndef OCCUPANCY_GRID_CIRCLE_UPDATE_ASSERT_SVH
`define OCCUPANCY_GRID_CIRCLE_UPDATE_ASSERT_SVH

// same-cycle implication
`define OGCU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OGCU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ogcu_pkg.sv =====
// Shared types and constants for the occupancy grid block.
// No dependencies.
`default_nettype none
package ogcu_pkg;
	localparam int MAP_CELLS  = 4096;
	localparam int ADDR_W     = 12;
	localparam int MAX_RADIUS = 15;
	localparam int RAD_W      = 4;
	localparam int VAL_W      = 16;
	localparam int POS_W      = 11;
	localparam int GRID_SIDE  = 64;

	localparam logic [1:0] MODE_OBST   = 2'd0;
	localparam logic [1:0] MODE_UPDATE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_RADIUS  = 3'd2;
	localparam logic [2:0] REG_OCC     = 3'd3;
	localparam logic [2:0] REG_FREE    = 3'd4;
	localparam logic [2:0] REG_FLOOR   = 3'd5;
	localparam logic [2:0] REG_CEILING = 3'd6;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CIRC,
		ST_FCOL,
		ST_FILL,
		ST_UPD,
		ST_UPD_LAST,
		ST_READ,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              lo_we;
		logic [ADDR_W-1:0] lo_addr;
		logic [VAL_W-1:0]  lo_data;
		logic              mk_we;
		logic [ADDR_W-1:0] mk_addr;
		logic              mk_data;
	} mem_ctrl_t;

	function automatic logic [6:0] dim_used(input logic [6:0] n);
		logic [6:0] r;
		if (n == 7'd0)
			r = 7'd1;
		else if (n > 7'(GRID_SIDE))
			r = 7'(GRID_SIDE);
		else
			r = n;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/ogcu_addr_unit.sv =====
// Cell address unit: clamps and range-checks a position, forms row*width+col.
// Depends on ogcu_pkg.
`default_nettype none
module ogcu_addr_unit (
	input  wire logic signed [ogcu_pkg::POS_W-1:0] col,
	input  wire logic signed [ogcu_pkg::POS_W-1:0] row,
	input  wire logic [6:0]                        w,
	input  wire logic [6:0]                        h,
	output logic [ogcu_pkg::ADDR_W-1:0]            idx,
	output logic                                   in_range
);
	import ogcu_pkg::*;

	logic [6:0]  w_m1, h_m1;
	logic [5:0]  c6, r6;
	logic [12:0] prod;

	assign w_m1 = w - 7'd1;
	assign h_m1 = h - 7'd1;

	always_comb begin
		if (col < 0)
			c6 = 6'd0;
		else if (col > signed'({4'b0, w_m1}))
			c6 = w_m1[5:0];
		else
			c6 = col[5:0];
		if (row < 0)
			r6 = 6'd0;
		else if (row > signed'({4'b0, h_m1}))
			r6 = h_m1[5:0];
		else
			r6 = row[5:0];
	end

	assign in_range = (col >= 0) && (col < signed'({4'b0, w}))
		&& (row >= 0) && (row < signed'({4'b0, h}));
	assign prod = 13'(r6) * 13'(w) + 13'(c6);
	assign idx  = prod[ADDR_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/ogcu_update_alu.sv =====
// Saturating log-odds step for one cell.
// Depends on ogcu_pkg.
`default_nettype none
module ogcu_update_alu (
	input  wire logic signed [ogcu_pkg::VAL_W-1:0] old_val,
	input  wire logic                              marked,
	input  wire logic signed [ogcu_pkg::VAL_W-1:0] occ_step,
	input  wire logic signed [ogcu_pkg::VAL_W-1:0] free_step,
	input  wire logic signed [ogcu_pkg::VAL_W-1:0] floor_val,
	input  wire logic signed [ogcu_pkg::VAL_W-1:0] ceil_val,
	output logic signed [ogcu_pkg::VAL_W-1:0]      new_val
);
	import ogcu_pkg::*;

	logic signed [VAL_W:0] sum, v;

	assign sum = (VAL_W+1)'(old_val) + (VAL_W+1)'(marked ? occ_step : free_step);

	always_comb begin
		v = sum;
		if (v < (VAL_W+1)'(floor_val))
			v = (VAL_W+1)'(floor_val);
		if (v > (VAL_W+1)'(ceil_val))
			v = (VAL_W+1)'(ceil_val);
	end

	assign new_val = v[VAL_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/ogcu_cell_mem.sv =====
// Log-odds store and mark bitmap: a shared read port and one write port each.
// Depends on ogcu_pkg.
`default_nettype none
module ogcu_cell_mem (
	input  wire logic                  clk,
	input  wire ogcu_pkg::mem_ctrl_t   ctrl,
	output logic signed [ogcu_pkg::VAL_W-1:0] lo_rd,
	output logic                       mk_rd
);
	import ogcu_pkg::*;

	logic [VAL_W-1:0] lo_mem [MAP_CELLS];
	logic             mk_mem [MAP_CELLS];
	logic [VAL_W-1:0] lo_rd_q;
	logic             mk_rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			lo_rd_q <= lo_mem[ctrl.rd_addr];
			mk_rd_q <= mk_mem[ctrl.rd_addr];
		end
		if (ctrl.lo_we)
			lo_mem[ctrl.lo_addr] <= ctrl.lo_data;
		if (ctrl.mk_we)
			mk_mem[ctrl.mk_addr] <= ctrl.mk_data;
	end

	assign lo_rd = signed'(lo_rd_q);
	assign mk_rd = mk_rd_q;
endmodule
`default_nettype wire

// ===== hdl/occupancy_grid_circle_update.sv =====
// Top level of the occupancy grid: sequencer, config registers, output register.
// Depends on ogcu_pkg, ogcu_addr_unit, ogcu_update_alu, ogcu_cell_mem.
//
// channel | signals                                  | direction
// in      | in_valid, in_stall, mode, position_*     | beat in
// out     | out_valid, out_stall, cell_value, in_map | beat out
// cfg     | cfg_we, cfg_index, cfg_data              | write only
//
// After reset a clearing pass zeroes all 4096 cells, with in_stall high.
// Apply update: one cell per cycle, read, then written back via a register.
// Obstacle: marks the outline, eight points per midpoint step, then fills the
// inside column by column in four quadrants. in_stall is high until the item is
// done. The result waits in an output register while out_stall is high.
`default_nettype none
module occupancy_grid_circle_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        mode,
	input  wire logic signed [7:0] position_col,
	input  wire logic signed [7:0] position_row,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [15:0]     cell_value,
	output logic                   in_map,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import ogcu_pkg::*;

	state_t state_q, state_nx;

	logic [6:0]              width_q, height_q;
	logic [RAD_W-1:0]        radius_q;
	logic signed [VAL_W-1:0] occ_q, free_q, floor_q, ceil_q;

	logic signed [POS_W-1:0] pc_q, pr_q, pc_in, pr_in;
	logic [6:0]              w_used, h_used;
	logic [12:0]             n_cells;

	logic [4:0]        x_q, y_q, x_nx, y_nx;
	logic signed [9:0] err_q, err_nx, d_xy;
	logic [2:0]        oct_q;
	logic [15:0]       hit_q [16];
	logic [3:0]        i_q, j_q;
	logic [4:0]        jlim_q, jfound;
	logic              circ_more, col_last, fill_last;

	logic [ADDR_W-1:0] k_q, k_s1;
	logic              wr_s1, upd_s1, inside_q;

	logic signed [5:0]       dx, dy;
	logic                    addr_on;
	logic signed [POS_W-1:0] a_col, a_row;
	logic [ADDR_W-1:0]       a_idx;
	logic                    a_inside;

	mem_ctrl_t               mctl;
	logic signed [VAL_W-1:0] lo_rd, alu_out;
	logic                    mk_rd;

	logic                    out_valid_q, in_map_q, out_free;
	logic signed [VAL_W-1:0] cell_value_q;

	assign w_used  = dim_used(width_q);
	assign h_used  = dim_used(height_q);
	assign n_cells = 13'(w_used) * 13'(h_used);
	assign pc_in   = signed'({5'b0, 6'((w_used - 7'd1) >> 1)}) + POS_W'(position_col);
	assign pr_in   = signed'({5'b0, 6'((h_used - 7'd1) >> 1)}) + POS_W'(position_row);
	assign out_free = !out_valid_q || !out_stall;

	// midpoint circle step
	always_comb begin
		y_nx = y_q + 5'd1;
		x_nx = x_q;
		d_xy = '0;
		if (err_q <= 0) begin
			err_nx = err_q + signed'({4'b0, y_nx, 1'b1});
		end else begin
			x_nx   = x_q - 5'd1;
			d_xy   = signed'({5'b0, y_nx}) - signed'({5'b0, x_nx});
			err_nx = err_q + (d_xy <<< 1) + 10'sd1;
		end
		circ_more = x_nx >= y_nx;
	end

	// first outline row of the current fill column
	always_comb begin
		jfound = {1'b0, radius_q};
		for (int j = 15; j >= 0; j--) begin
			if (hit_q[i_q][j] && (5'(j) < {1'b0, radius_q}))
				jfound = 5'(j);
		end
	end

	assign col_last  = ({1'b0, i_q} + 5'd1) == {1'b0, radius_q};
	assign fill_last = ({1'b0, j_q} + 5'd1) == jlim_q;

	// mark offsets
	always_comb begin
		dx = '0;
		dy = '0;
		if (state_q == ST_CIRC) begin
			case (oct_q)
				3'd0: begin dx =  signed'({1'b0, x_q}); dy =  signed'({1'b0, y_q}); end
				3'd1: begin dx =  signed'({1'b0, y_q}); dy =  signed'({1'b0, x_q}); end
				3'd2: begin dx = -signed'({1'b0, y_q}); dy =  signed'({1'b0, x_q}); end
				3'd3: begin dx = -signed'({1'b0, x_q}); dy =  signed'({1'b0, y_q}); end
				3'd4: begin dx = -signed'({1'b0, x_q}); dy = -signed'({1'b0, y_q}); end
				3'd5: begin dx = -signed'({1'b0, y_q}); dy = -signed'({1'b0, x_q}); end
				3'd6: begin dx =  signed'({1'b0, y_q}); dy = -signed'({1'b0, x_q}); end
				3'd7: begin dx =  signed'({1'b0, x_q}); dy = -signed'({1'b0, y_q}); end
				default: begin dx = '0; dy = '0; end
			endcase
		end else if (state_q == ST_FILL) begin
			case (oct_q[1:0])
				2'd0: begin dx =  signed'({2'b0, i_q}); dy =  signed'({2'b0, j_q}); end
				2'd1: begin dx = -signed'({2'b0, i_q}); dy = -signed'({2'b0, j_q}); end
				2'd2: begin dx =  signed'({2'b0, i_q}); dy = -signed'({2'b0, j_q}); end
				2'd3: begin dx = -signed'({2'b0, i_q}); dy =  signed'({2'b0, j_q}); end
				default: begin dx = '0; dy = '0; end
			endcase
		end
	end

	assign addr_on = 1'b1;
	assign a_col = addr_on ? pc_q + POS_W'(dx) : pc_q;
	assign a_row = pr_q + POS_W'(dy);

	ogcu_addr_unit u_addr (
		.col      (a_col),
		.row      (a_row),
		.w        (w_used),
		.h        (h_used),
		.idx      (a_idx),
		.in_range (a_inside)
	);

	ogcu_update_alu u_alu (
		.old_val   (lo_rd),
		.marked    (mk_rd),
		.occ_step  (occ_q),
		.free_step (free_q),
		.floor_val (floor_q),
		.ceil_val  (ceil_q),
		.new_val   (alu_out)
	);

	ogcu_cell_mem u_mem (
		.clk   (clk),
		.ctrl  (mctl),
		.lo_rd (lo_rd),
		.mk_rd (mk_rd)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:
				if (k_q == ADDR_W'(MAP_CELLS - 1))
					state_nx = ST_IDLE;
			ST_IDLE:
				if (in_valid) begin
					case (mode)
						MODE_OBST:   state_nx = ST_CIRC;
						MODE_UPDATE: state_nx = ST_UPD;
						MODE_READ:   state_nx = ST_READ;
						default:     state_nx = ST_FINISH;
					endcase
				end
			ST_CIRC:
				if (oct_q == 3'd7 && !circ_more)
					state_nx = (radius_q == '0) ? ST_FINISH : ST_FCOL;
			ST_FCOL:
				if (jfound != 5'd0)
					state_nx = ST_FILL;
				else if (col_last)
					state_nx = ST_FINISH;
			ST_FILL:
				if (oct_q[1:0] == 2'd3 && fill_last)
					state_nx = col_last ? ST_FINISH : ST_FCOL;
			ST_UPD:
				if (k_q == ADDR_W'(MAP_CELLS - 1))
					state_nx = ST_UPD_LAST;
			ST_UPD_LAST: state_nx = ST_FINISH;
			ST_READ:     state_nx = ST_FINISH;
			ST_FINISH:
				if (out_free)
					state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		mctl = '0;
		case (state_q)
			ST_CLEAR: begin
				mctl.lo_we   = 1'b1;
				mctl.lo_addr = k_q;
				mctl.mk_we   = 1'b1;
				mctl.mk_addr = k_q;
			end
			ST_CIRC, ST_FILL: begin
				mctl.mk_we   = 1'b1;
				mctl.mk_addr = a_idx;
				mctl.mk_data = 1'b1;
			end
			ST_UPD, ST_UPD_LAST: begin
				mctl.rd_en   = (state_q == ST_UPD);
				mctl.rd_addr = k_q;
				mctl.lo_we   = wr_s1 && upd_s1;
				mctl.lo_addr = k_s1;
				mctl.lo_data = alu_out;
				mctl.mk_we   = wr_s1;
				mctl.mk_addr = k_s1;
			end
			ST_READ: begin
				mctl.rd_en   = 1'b1;
				mctl.rd_addr = a_idx;
			end
			default: mctl = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			width_q  <= 7'd61;
			height_q <= 7'd41;
			radius_q <= 4'd5;
			occ_q    <= 16'sd870;
			free_q   <= -16'sd410;
			floor_q  <= -16'sd3072;
			ceil_q   <= 16'sd4096;
			k_q      <= '0;
			wr_s1    <= 1'b0;
			upd_s1   <= 1'b0;
			oct_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			jlim_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			err_q    <= '0;
			inside_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < 16; a++)
				hit_q[a] <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:   width_q  <= cfg_data[6:0];
					REG_HEIGHT:  height_q <= cfg_data[6:0];
					REG_RADIUS:  radius_q <= cfg_data[3:0];
					REG_OCC:     occ_q    <= signed'(cfg_data);
					REG_FREE:    free_q   <= signed'(cfg_data);
					REG_FLOOR:   floor_q  <= signed'(cfg_data);
					REG_CEILING: ceil_q   <= signed'(cfg_data);
					default: ;
				endcase
			end
			wr_s1  <= (state_q == ST_UPD);
			k_s1   <= k_q;
			upd_s1 <= {1'b0, k_q} < n_cells;
			out_valid_q <= ((state_q == ST_FINISH) && out_free) || (out_valid_q && out_stall);
			case (state_q)
				ST_CLEAR:
					k_q <= k_q + 1'b1;
				ST_IDLE:
					if (in_valid) begin
						pc_q     <= pc_in;
						pr_q     <= pr_in;
						k_q      <= '0;
						inside_q <= 1'b0;
						x_q      <= {1'b0, radius_q};
						y_q      <= '0;
						err_q    <= '0;
						oct_q    <= '0;
						i_q      <= '0;
						for (int a = 0; a < 16; a++)
							hit_q[a] <= '0;
					end
				ST_CIRC: begin
					if (oct_q == 3'd0)
						hit_q[x_q[3:0]][y_q[3:0]] <= 1'b1;
					if (oct_q == 3'd1)
						hit_q[y_q[3:0]][x_q[3:0]] <= 1'b1;
					oct_q <= oct_q + 3'd1;
					if (oct_q == 3'd7) begin
						x_q   <= x_nx;
						y_q   <= y_nx;
						err_q <= err_nx;
					end
				end
				ST_FCOL: begin
					jlim_q <= jfound;
					j_q    <= '0;
					oct_q  <= '0;
					if (jfound == 5'd0)
						i_q <= i_q + 4'd1;
				end
				ST_FILL: begin
					if (oct_q[1:0] == 2'd3) begin
						oct_q <= '0;
						j_q   <= j_q + 4'd1;
						if (fill_last)
							i_q <= i_q + 4'd1;
					end else begin
						oct_q <= oct_q + 3'd1;
					end
				end
				ST_UPD:
					k_q <= k_q + 1'b1;
				ST_READ:
					inside_q <= a_inside;
				ST_FINISH:
					if (out_free) begin
						in_map_q     <= inside_q;
						cell_value_q <= inside_q ? lo_rd : '0;
					end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign in_map     = in_map_q;
	assign cell_value = cell_value_q;
endmodule
`default_nettype wire

// ===== hdl/ogcu_checker.sv =====
// Port-level checks for the occupancy grid block, bound to the top level.
// Depends on occupancy_grid_circle_update_assert.svh.
`default_nettype none
`include "occupancy_grid_circle_update_assert.svh"
module ogcu_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [1:0]        mode,
	input wire logic signed [7:0] position_col,
	input wire logic signed [7:0] position_row,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic signed [15:0] cell_value,
	input wire logic              in_map,
	input wire logic              cfg_we,
	input wire logic [2:0]        cfg_index,
	input wire logic [15:0]       cfg_data
);
	`OGCU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "out beat dropped")
	`OGCU_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(cell_value) && $stable(in_map), "out beat changed")
	`OGCU_ASSERT_IMP(a_zero_outside, clk, arst_n, out_valid && !in_map, cell_value == 16'sd0, "value outside map")
	`OGCU_ASSERT_NXT(a_busy_after, clk, arst_n, in_valid && !in_stall, in_stall, "not busy after beat")
endmodule

bind occupancy_grid_circle_update ogcu_checker u_ogcu_checker (.*);
`default_nettype wire
